>>> hw/rtl/tkm_pkg.sv
// Shared types, constants and helpers for the timestamp k-way merge block.
// Used by tkm_cell and timestamp_kway_merge_core; depends on nothing else.

package tkm_pkg;

	// Sizing of the merge.
	localparam int MAX_STREAMS = 16;
	localparam int TIME_BITS   = 48;
	localparam int HANDLE_BITS = 32;
	localparam int STREAM_BITS = 4;
	localparam int CFG_BITS    = 5;
	localparam int SLOT_BITS   = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int CNT_BITS    = $clog2(MAX_STREAMS + 1);

	// Input command codes.
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_END    = 1'b1;

	// Result kind codes.
	localparam logic [1:0] KIND_RECORD   = 2'd0;
	localparam logic [1:0] KIND_FINISHED = 2'd1;
	localparam logic [1:0] KIND_REJECT   = 2'd2;

	// Contents of one slot head.
	typedef struct packed {
		logic [STREAM_BITS-1:0] src;
		logic [TIME_BITS-1:0]   tstamp;
		logic [HANDLE_BITS-1:0] rec_handle;
	} slot_data_t;

	// Running minimum that travels down the row of cells.
	typedef struct packed {
		logic                 vld;
		logic                 found;
		logic [SLOT_BITS-1:0] idx;
		slot_data_t           data;
	} scan_tok_t;

	// Number of streams in use, with out-of-range counts clamped.
	function automatic logic [CNT_BITS-1:0] active_count(input logic [CFG_BITS-1:0] cfg);
		logic [CNT_BITS-1:0] n;
		if (cfg == '0) begin
			n = CNT_BITS'(1);
		end else if (32'(cfg) > MAX_STREAMS) begin
			n = CNT_BITS'(MAX_STREAMS);
		end else begin
			n = CNT_BITS'(cfg);
		end
		return n;
	endfunction

endpackage

>>> hw/rtl/timestamp_kway_merge_core.sv
// Top level of the timestamp k-way merge: control sequencer and row of cells.
// Depends on tkm_pkg and tkm_cell.
//
// Usage: write stream_count through cfg_wr_en/cfg_wr_data while the block is
// idle. After reset the block is in the fill phase and takes the first item
// of each stream in stream order; those transfers return nothing until the
// last one, which returns the first merged result; a wrong stream is rejected.
// After that, every input transfer refills (or ends) the stream named in the
// last merged record and returns the next merged record, a "finished" result
// once no stream is left, or a reject when the item came from another stream.
// Sequencing: a fill item that returns nothing leaves the block idle and ready
// for the next item. A reject is held as a pending result and enters the
// output register once that register is free. An item that causes an emission
// starts the minimum scan, which moves one slot cell per cycle down the row.
// The next input transfer is taken in the cycle after the result is loaded
// into the output register.
// Reset clears the fill state, the slot count and the handshakes; the stream
// count returns to one. A stalled result stays in the output register while
// the next input is taken; a new result waits until that register is free.

module timestamp_kway_merge_core import tkm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_BITS-1:0]    cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic [STREAM_BITS-1:0] source_stream,
	input  logic [TIME_BITS-1:0]   time_mark,
	input  logic [HANDLE_BITS-1:0] record_handle,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             result_kind,
	output logic [STREAM_BITS-1:0] out_stream,
	output logic [TIME_BITS-1:0]   out_time,
	output logic [HANDLE_BITS-1:0] out_handle
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_OUT} state_t;
	typedef enum logic [1:0] {DEC_NONE, DEC_SCAN, DEC_REJECT} dec_t;

	state_t                 state_q;
	logic [CFG_BITS-1:0]    stream_cnt_q;
	logic                   filling_q;
	logic [CNT_BITS-1:0]    fill_q;
	logic [CNT_BITS-1:0]    live_q;
	logic [SLOT_BITS-1:0]   awaited_q;
	logic [STREAM_BITS-1:0] await_src_q;
	logic                   go_q;

	logic [1:0]             pend_kind_q;
	logic [STREAM_BITS-1:0] pend_stream_q;
	logic [TIME_BITS-1:0]   pend_time_q;
	logic [HANDLE_BITS-1:0] pend_handle_q;

	logic                   out_valid_q;
	logic [1:0]             out_kind_q;
	logic [STREAM_BITS-1:0] out_stream_q;
	logic [TIME_BITS-1:0]   out_time_q;
	logic [HANDLE_BITS-1:0] out_handle_q;

	scan_tok_t  tok_w [MAX_STREAMS+1];
	slot_data_t head_w [MAX_STREAMS];
	logic [MAX_STREAMS-1:0] live_vec;
	logic [MAX_STREAMS-1:0] cell_we;

	logic                   in_acc;
	logic                   out_free;
	logic [CNT_BITS-1:0]    act_n;
	logic [SLOT_BITS-1:0]   last_slot;
	dec_t                   dec;
	logic                   fill_adv;
	logic                   fill_end;
	logic                   live_inc;
	logic                   live_dec;
	logic [STREAM_BITS-1:0] rej_stream;
	logic                   we;
	logic [SLOT_BITS-1:0]   we_slot;
	slot_data_t             wd;
	scan_tok_t              end_tok;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign act_n     = active_count(stream_cnt_q);
	assign last_slot = SLOT_BITS'(live_q - CNT_BITS'(1));
	assign end_tok   = tok_w[MAX_STREAMS];

	// Decode of an input transfer against the current merge state.
	always_comb begin
		dec        = DEC_NONE;
		fill_adv   = 1'b0;
		fill_end   = 1'b0;
		live_inc   = 1'b0;
		live_dec   = 1'b0;
		rej_stream = '0;
		we         = 1'b0;
		we_slot    = '0;
		wd.src        = source_stream;
		wd.tstamp     = time_mark;
		wd.rec_handle = record_handle;
		if (filling_q) begin
			if (fill_q >= act_n) begin
				dec      = DEC_SCAN;
				fill_end = 1'b1;
			end else if (32'(source_stream) != 32'(fill_q)) begin
				dec        = DEC_REJECT;
				rej_stream = STREAM_BITS'(fill_q);
			end else begin
				if (command == CMD_RECORD && 32'(live_q) < MAX_STREAMS) begin
					we       = 1'b1;
					we_slot  = SLOT_BITS'(live_q);
					live_inc = 1'b1;
				end
				fill_adv = 1'b1;
				if ((fill_q + CNT_BITS'(1)) >= act_n) begin
					dec      = DEC_SCAN;
					fill_end = 1'b1;
				end
			end
		end else begin
			if (live_q == '0 || CNT_BITS'(awaited_q) >= live_q) begin
				dec = DEC_REJECT;
			end else if (source_stream != await_src_q) begin
				dec        = DEC_REJECT;
				rej_stream = await_src_q;
			end else if (command == CMD_RECORD) begin
				dec     = DEC_SCAN;
				we      = 1'b1;
				we_slot = awaited_q;
			end else begin
				dec      = DEC_SCAN;
				live_dec = 1'b1;
				if (awaited_q != last_slot) begin
					we      = 1'b1;
					we_slot = awaited_q;
					wd      = head_w[last_slot];
				end
			end
		end
	end

	// Scan token entering the first cell.
	assign tok_w[0].vld   = go_q;
	assign tok_w[0].found = 1'b0;
	assign tok_w[0].idx   = '0;
	assign tok_w[0].data  = '0;

	// Row of slot cells.
	for (genvar i = 0; i < MAX_STREAMS; i++) begin : g_cell
		assign live_vec[i] = (CNT_BITS'(i) < live_q);
		assign cell_we[i]  = in_acc && we && (we_slot == SLOT_BITS'(i));

		tkm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (SLOT_BITS'(i)),
			.live     (live_vec[i]),
			.wr_en    (cell_we[i]),
			.wr_data  (wd),
			.tok_in   (tok_w[i]),
			.tok_out  (tok_w[i+1]),
			.head     (head_w[i])
		);
	end

	// Sequencer, merge state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			stream_cnt_q  <= CFG_BITS'(1);
			filling_q     <= 1'b1;
			fill_q        <= '0;
			live_q        <= '0;
			awaited_q     <= '0;
			await_src_q   <= '0;
			go_q          <= 1'b0;
			pend_kind_q   <= KIND_RECORD;
			pend_stream_q <= '0;
			pend_time_q   <= '0;
			pend_handle_q <= '0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= KIND_RECORD;
			out_stream_q  <= '0;
			out_time_q    <= '0;
			out_handle_q  <= '0;
		end else begin
			go_q <= 1'b0;
			if (cfg_wr_en) begin
				stream_cnt_q <= cfg_wr_data;
			end
			// A pending result enters the output register once it is free;
			// otherwise a result transfer empties the register.
			if (state_q == ST_OUT && out_free) begin
				out_valid_q  <= 1'b1;
				out_kind_q   <= pend_kind_q;
				out_stream_q <= pend_stream_q;
				out_time_q   <= pend_time_q;
				out_handle_q <= pend_handle_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (fill_adv) begin
							fill_q <= fill_q + CNT_BITS'(1);
						end
						if (fill_end) begin
							filling_q <= 1'b0;
						end
						if (live_inc) begin
							live_q <= live_q + CNT_BITS'(1);
						end else if (live_dec) begin
							live_q <= live_q - CNT_BITS'(1);
						end
						unique case (dec)
							DEC_SCAN: begin
								go_q    <= 1'b1;
								state_q <= ST_SCAN;
							end
							DEC_REJECT: begin
								pend_kind_q   <= KIND_REJECT;
								pend_stream_q <= rej_stream;
								pend_time_q   <= '0;
								pend_handle_q <= '0;
								state_q       <= ST_OUT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (end_tok.vld) begin
						if (end_tok.found) begin
							pend_kind_q   <= KIND_RECORD;
							pend_stream_q <= end_tok.data.src;
							pend_time_q   <= end_tok.data.tstamp;
							pend_handle_q <= end_tok.data.rec_handle;
							awaited_q     <= end_tok.idx;
							await_src_q   <= end_tok.data.src;
						end else begin
							pend_kind_q   <= KIND_FINISHED;
							pend_stream_q <= '0;
							pend_time_q   <= '0;
							pend_handle_q <= '0;
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign out_stream  = out_stream_q;
	assign out_time    = out_time_q;
	assign out_handle  = out_handle_q;

endmodule

>>> hw/rtl/tkm_cell.sv
// One slot of the merge: holds a slot head and one stage of the minimum scan.
// Depends on tkm_pkg for the slot and scan token types.

module tkm_cell import tkm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SLOT_BITS-1:0] cell_idx,
	input  logic                 live,
	input  logic                 wr_en,
	input  slot_data_t           wr_data,
	input  scan_tok_t            tok_in,
	output scan_tok_t            tok_out,
	output slot_data_t           head
);

	slot_data_t head_q;
	logic       tok_vld_q;
	logic       tok_found_q;
	logic [SLOT_BITS-1:0] tok_idx_q;
	slot_data_t tok_data_q;
	logic       take;

	// This slot wins when it is live and not later than the best so far;
	// ties go to the higher slot, which is the later cell in the row.
	assign take = live && (!tok_in.found || (head_q.tstamp <= tok_in.data.tstamp));

	// Slot head storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			head_q <= wr_data;
		end
	end

	// Scan stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
		end
	end

	// Scan stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			tok_found_q <= 1'b1;
			tok_idx_q   <= cell_idx;
			tok_data_q  <= head_q;
		end else begin
			tok_found_q <= tok_in.found;
			tok_idx_q   <= tok_in.idx;
			tok_data_q  <= tok_in.data;
		end
	end

	assign tok_out.vld   = tok_vld_q;
	assign tok_out.found = tok_found_q;
	assign tok_out.idx   = tok_idx_q;
	assign tok_out.data  = tok_data_q;
	assign head          = head_q;

endmodule

>>> bench/timestamp_kway_merge_core_tb.sv
// Self-checking testbench for timestamp_kway_merge_core: drives timestamped items,
// predicts the merged output order and compares every result transfer.
// Depends on tkm_pkg and the RTL of the merge block.

module timestamp_kway_merge_core_tb import tkm_pkg::*; ();

	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 5000;
	localparam int SETTLE_WAIT  = MAX_STREAMS + 8;

	// One merged output as the block should present it.
	typedef struct {
		logic [1:0]             kind;
		logic [STREAM_BITS-1:0] strm;
		logic [TIME_BITS-1:0]   tstamp;
		logic [HANDLE_BITS-1:0] hnd;
	} merged_out_t;

	// Predicts the merge and holds the results still to come out of the block.
	class merge_scoreboard;
		slot_data_t          heads[MAX_STREAMS];
		int                  live;
		int                  fill_pos;
		int                  awaited;
		bit                  filling;
		logic [CFG_BITS-1:0] count_reg;
		merged_out_t         merge_order_q[$];
		int                  errors;

		function new();
			live      = 0;
			fill_pos  = 0;
			awaited   = 0;
			filling   = 1'b1;
			count_reg = CFG_BITS'(1);
			errors    = 0;
		endfunction

		function void write_count(input logic [CFG_BITS-1:0] v);
			count_reg = v;
		endfunction

		// Clamp the written count to the range the block supports.
		function int streams_in_use();
			if (count_reg == '0) begin
				return 1;
			end
			if (int'(count_reg) > MAX_STREAMS) begin
				return MAX_STREAMS;
			end
			return int'(count_reg);
		endfunction

		function void push_result(input logic [1:0] kind, input int strm,
				input logic [TIME_BITS-1:0] tstamp, input logic [HANDLE_BITS-1:0] hnd);
			merged_out_t r;
			r.kind   = kind;
			r.strm   = STREAM_BITS'(strm);
			r.tstamp = tstamp;
			r.hnd    = hnd;
			merge_order_q.push_back(r);
		endfunction

		// Pick the earliest head; on equal times the later slot wins.
		function void emit_earliest();
			int best;
			best = 0;
			if (live == 0) begin
				push_result(KIND_FINISHED, 0, '0, '0);
				return;
			end
			for (int i = 1; i < live; i++) begin
				if (heads[i].tstamp <= heads[best].tstamp) begin
					best = i;
				end
			end
			awaited = best;
			push_result(KIND_RECORD, int'(heads[best].src), heads[best].tstamp,
				heads[best].rec_handle);
		endfunction

		// Stream the block wants next, as far as the sender can know it.
		function logic [STREAM_BITS-1:0] awaited_stream();
			if (filling) begin
				return STREAM_BITS'(fill_pos);
			end
			if (live == 0 || awaited >= live) begin
				return '0;
			end
			return heads[awaited].src;
		endfunction

		function bit finished();
			return !filling && live == 0;
		endfunction

		// Update the prediction with one accepted input transfer.
		function void take_item(input logic cmd, input logic [STREAM_BITS-1:0] src,
				input logic [TIME_BITS-1:0] tstamp, input logic [HANDLE_BITS-1:0] hnd);
			int n;
			int last;
			if (filling) begin
				n = streams_in_use();
				// The count was lowered below the fill position: the item is dropped.
				if (fill_pos >= n) begin
					filling = 1'b0;
					emit_earliest();
					return;
				end
				if (int'(src) != fill_pos) begin
					push_result(KIND_REJECT, fill_pos, '0, '0);
					return;
				end
				if (cmd == CMD_RECORD && live < MAX_STREAMS) begin
					heads[live].src        = src;
					heads[live].tstamp     = tstamp;
					heads[live].rec_handle = hnd;
					live++;
				end
				fill_pos++;
				if (fill_pos >= n) begin
					filling = 1'b0;
					emit_earliest();
				end
				return;
			end
			if (live == 0 || awaited >= live) begin
				push_result(KIND_REJECT, 0, '0, '0);
				return;
			end
			if (src != heads[awaited].src) begin
				push_result(KIND_REJECT, int'(heads[awaited].src), '0, '0);
				return;
			end
			if (cmd == CMD_RECORD) begin
				heads[awaited].tstamp     = tstamp;
				heads[awaited].rec_handle = hnd;
			end else begin
				// The last live slot moves into the place of the ended stream.
				last = live - 1;
				if (awaited != last) begin
					heads[awaited] = heads[last];
				end
				live = last;
			end
			emit_earliest();
		endfunction

		// Compare one accepted result transfer with the oldest expectation.
		function void check_result(input logic [1:0] kind, input logic [STREAM_BITS-1:0] strm,
				input logic [TIME_BITS-1:0] tstamp, input logic [HANDLE_BITS-1:0] hnd);
			merged_out_t e;
			if (merge_order_q.size() == 0) begin
				$error("result of kind %0d arrived with no result expected", kind);
				errors++;
				return;
			end
			e = merge_order_q.pop_front();
			if (kind !== e.kind) begin
				$error("result_kind: expected %0d, actual %0d", e.kind, kind);
				errors++;
			end
			if (strm !== e.strm) begin
				$error("out_stream: expected %0d, actual %0d", e.strm, strm);
				errors++;
			end
			if (tstamp !== e.tstamp) begin
				$error("out_time: expected %0h, actual %0h", e.tstamp, tstamp);
				errors++;
			end
			if (hnd !== e.hnd) begin
				$error("out_handle: expected %0h, actual %0h", e.hnd, hnd);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   cfg_wr_en     = 1'b0;
	logic [CFG_BITS-1:0]    cfg_wr_data   = '0;
	logic                   in_valid      = 1'b0;
	logic                   in_stall;
	logic                   command       = CMD_RECORD;
	logic [STREAM_BITS-1:0] source_stream = '0;
	logic [TIME_BITS-1:0]   time_mark     = '0;
	logic [HANDLE_BITS-1:0] record_handle = '0;
	logic                   out_valid;
	logic                   out_stall     = 1'b0;
	logic [1:0]             result_kind;
	logic [STREAM_BITS-1:0] out_stream;
	logic [TIME_BITS-1:0]   out_time;
	logic [HANDLE_BITS-1:0] out_handle;

	// Requests from the sender to the receiver process.
	logic hold_req = 1'b0;
	logic calm     = 1'b0;

	merge_scoreboard sb = new();

	timestamp_kway_merge_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.source_stream (source_stream),
		.time_mark     (time_mark),
		.record_handle (record_handle),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.out_stream    (out_stream),
		.out_time      (out_time),
		.out_handle    (out_handle)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: checks result transfers and drives the stall pattern.
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sb.check_result(result_kind, out_stream, out_time, out_handle);
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 9);
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one item and wait for its transfer.
	task automatic send_item(input logic cmd, input logic [STREAM_BITS-1:0] src,
			input logic [TIME_BITS-1:0] tstamp, input logic [HANDLE_BITS-1:0] hnd);
		in_valid      <= 1'b1;
		command       <= cmd;
		source_stream <= src;
		time_mark     <= tstamp;
		record_handle <= hnd;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.take_item(cmd, src, tstamp, hnd);
	endtask

	// Sender gap, about nine times in a hundred items.
	task automatic maybe_pause(input bit quiet);
		if (!quiet && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Let the block drain completely before touching the register.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.merge_order_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_stream_count(input logic [CFG_BITS-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		sb.write_count(v);
		cfg_wr_en <= 1'b0;
	endtask

	// Times cluster on a few small values so that ties come up often.
	function automatic logic [TIME_BITS-1:0] pick_time();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			return TIME_BITS'($urandom_range(0, 7));
		end else if (r == 4) begin
			return '1;
		end else if (r == 5) begin
			return '0;
		end
		return TIME_BITS'({$urandom(), $urandom()});
	endfunction

	// Mostly well-formed refills of the awaited stream, some noise.
	task automatic send_random(input bit allow_end, input bit quiet);
		logic                   cmd;
		logic [STREAM_BITS-1:0] src;
		if ($urandom_range(0, 99) < 88) begin
			src = sb.awaited_stream();
			cmd = (allow_end && sb.live > 3 && $urandom_range(0, 99) < 2) ? CMD_END : CMD_RECORD;
		end else begin
			src = STREAM_BITS'($urandom_range(0, 15));
			cmd = ($urandom_range(0, 1) == 1) ? CMD_END : CMD_RECORD;
			// Keep enough streams alive for the long random part.
			if (src == sb.awaited_stream() && sb.live <= 3) begin
				cmd = CMD_RECORD;
			end
		end
		send_item(cmd, src, pick_time(), HANDLE_BITS'($urandom()));
		maybe_pause(quiet);
	endtask

	// Main sequence: fill, lowered count, random phases, wind-down.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Count above the maximum acts as sixteen streams.
		write_stream_count(CFG_BITS'(31));

		// Fill: extremes, a wrong stream, and streams that end at once.
		send_item(CMD_RECORD, 4'd0, '0, '0);
		send_item(CMD_RECORD, 4'd5, TIME_BITS'(5), HANDLE_BITS'(5));
		send_item(CMD_RECORD, 4'd1, '1, '1);
		send_item(CMD_END, 4'd2, '1, '1);
		for (int s = 3; s < 14; s++) begin
			if (s == 7) begin
				send_item(CMD_END, STREAM_BITS'(s), '0, '0);
			end else begin
				send_item(CMD_RECORD, STREAM_BITS'(s), TIME_BITS'(100 * (s % 4)),
					HANDLE_BITS'($urandom()));
			end
		end
		settle();

		// Count lowered below the fill position: the next item ends the fill.
		write_stream_count('0);
		send_item(CMD_END, 4'd15, '1, '1);
		send_item(CMD_RECORD, sb.awaited_stream() ^ 4'd1, '0, '0);
		send_item(CMD_RECORD, sb.awaited_stream(), '0, '1);
		send_item(CMD_RECORD, sb.awaited_stream(), '1, '0);
		send_item(CMD_END, sb.awaited_stream(), '0, '0);
		settle();

		// First random phase, with one long receiver hold-off.
		write_stream_count(CFG_BITS'(16));
		for (int i = 0; i < 480; i++) begin
			if (i == 100) begin
				hold_req <= 1'b1;
			end
			send_random(1'b0, 1'b0);
		end
		settle();

		// Second random phase, starting with a stretch without any idling.
		write_stream_count(CFG_BITS'(1));
		calm <= 1'b1;
		for (int i = 0; i < 480; i++) begin
			if (i == 200) begin
				calm <= 1'b0;
			end
			send_random(1'b1, i < 200);
		end
		settle();

		// Last phase: more random items, then end every stream.
		write_stream_count(CFG_BITS'(9));
		for (int i = 0; i < 440; i++) begin
			send_random(1'b1, 1'b0);
		end
		while (!sb.finished()) begin
			if ($urandom_range(0, 3) == 0) begin
				send_item(CMD_RECORD, sb.awaited_stream(), pick_time(), HANDLE_BITS'($urandom()));
			end else begin
				send_item(CMD_END, sb.awaited_stream(), '0, '0);
			end
			maybe_pause(1'b0);
		end

		// Everything after the finish is rejected.
		for (int i = 0; i < 6; i++) begin
			send_item(($urandom_range(0, 1) == 1) ? CMD_END : CMD_RECORD,
				STREAM_BITS'($urandom_range(0, 15)), pick_time(), HANDLE_BITS'($urandom()));
		end
		settle();

		if (sb.errors == 0 && sb.merge_order_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
